/* rtl/bse_pkg.sv */
`default_nettype none

package bse_pkg;

    // Fixed-point format of the coordinate datapath
    localparam int FRACTION_BITS = 28;
    localparam int MAG_FRACTION  = 24;

    // Multiplier operand: magnitudes clamped to 16.0 need FRACTION_BITS+5 bits
    localparam int OPW  = FRACTION_BITS + 5;
    localparam int PW   = 2 * OPW;
    // Product realigned to FRACTION_BITS, and realigned for the doubled cross term
    localparam int SQW  = PW - FRACTION_BITS;
    localparam int XW   = SQW + 1;
    // Signed width of cx, cy, zx, zy
    localparam int ZW   = 48;
    // Sum of the two squares, and that sum realigned to MAG_FRACTION
    localparam int MSW  = SQW + 1;
    localparam int MAGW = MSW - (FRACTION_BITS - MAG_FRACTION);

    // Configuration register indices
    localparam int IDXW = 3;
    localparam logic [IDXW-1:0] REG_X_ORIGIN   = 3'd0;
    localparam logic [IDXW-1:0] REG_X_STEP     = 3'd1;
    localparam logic [IDXW-1:0] REG_Y_ORIGIN   = 3'd2;
    localparam logic [IDXW-1:0] REG_Y_STEP     = 3'd3;
    localparam logic [IDXW-1:0] REG_ITER_LIMIT = 3'd4;

    // Register reset values
    localparam logic [31:0] RST_X_ORIGIN   = 32'hE000_0000;
    localparam logic [30:0] RST_X_STEP     = 31'd1179648;
    localparam logic [31:0] RST_Y_ORIGIN   = 32'd671088640;
    localparam logic [30:0] RST_Y_STEP     = 31'd1048576;
    localparam logic [15:0] RST_ITER_LIMIT = 16'd70;

    typedef struct packed {
        logic [9:0] column;
        logic [9:0] row;
    } in_item_t;

    typedef struct packed {
        logic [9:0]  pixel_column;
        logic [9:0]  pixel_row;
        logic        escaped;
        logic [15:0] escape_count;
        logic [31:0] escape_magnitude;
    } out_item_t;

    typedef struct packed {
        logic [31:0] x_origin;
        logic [30:0] x_step;
        logic [31:0] y_origin;
        logic [30:0] y_step;
        logic [15:0] iteration_limit;
    } cfg_t;

endpackage

`default_nettype wire

/* rtl/bse_cfg_regs.sv */
`default_nettype none

module bse_cfg_regs (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [bse_pkg::IDXW-1:0]   cfg_index,
    input  wire logic [31:0]                cfg_data,
    output bse_pkg::cfg_t                   cfg
);

    bse_pkg::cfg_t cfg_reg;

    // Writes are always taken; unknown indices are dropped
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_origin        <= bse_pkg::RST_X_ORIGIN;
            cfg_reg.x_step          <= bse_pkg::RST_X_STEP;
            cfg_reg.y_origin        <= bse_pkg::RST_Y_ORIGIN;
            cfg_reg.y_step          <= bse_pkg::RST_Y_STEP;
            cfg_reg.iteration_limit <= bse_pkg::RST_ITER_LIMIT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bse_pkg::REG_X_ORIGIN:   cfg_reg.x_origin        <= cfg_data;
                bse_pkg::REG_X_STEP:     cfg_reg.x_step          <= cfg_data[30:0];
                bse_pkg::REG_Y_ORIGIN:   cfg_reg.y_origin        <= cfg_data;
                bse_pkg::REG_Y_STEP:     cfg_reg.y_step          <= cfg_data[30:0];
                bse_pkg::REG_ITER_LIMIT: cfg_reg.iteration_limit <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/bse_mult.sv */
`default_nettype none

module bse_mult (
    input  wire logic                      aclk,
    input  wire logic [bse_pkg::OPW-1:0]   op_a,
    input  wire logic [bse_pkg::OPW-1:0]   op_b,
    output logic      [bse_pkg::PW-1:0]    prod
);

    logic [bse_pkg::PW-1:0] prod_reg;

    // Shared unsigned multiplier, product registered
    always_ff @(posedge aclk) begin
        prod_reg <= {{bse_pkg::OPW{1'b0}}, op_a} * {{bse_pkg::OPW{1'b0}}, op_b};
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* rtl/bse_core.sv */
`default_nettype none

module bse_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire bse_pkg::cfg_t       cfg,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire bse_pkg::in_item_t   in_item,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output bse_pkg::out_item_t       res_item
);

    localparam int FB  = bse_pkg::FRACTION_BITS;
    localparam int OPW = bse_pkg::OPW;
    localparam int PW  = bse_pkg::PW;
    localparam int SQW = bse_pkg::SQW;
    localparam int XW  = bse_pkg::XW;
    localparam int ZW  = bse_pkg::ZW;
    localparam int MSW = bse_pkg::MSW;
    localparam int MAGW = bse_pkg::MAGW;

    localparam logic [ZW-1:0]  CLAMP_Z = ZW'(1) << (FB + 4);
    localparam logic [MSW-1:0] FOUR    = MSW'(4) << FB;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CX    = 4'd1;
    localparam logic [3:0] S_CY    = 4'd2;
    localparam logic [3:0] S_INIT  = 4'd3;
    localparam logic [3:0] S_CROSS = 4'd4;
    localparam logic [3:0] S_UPD   = 4'd5;
    localparam logic [3:0] S_SQX   = 4'd6;
    localparam logic [3:0] S_SQY   = 4'd7;
    localparam logic [3:0] S_CHK   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]              state_reg, state_next;
    bse_pkg::in_item_t       pix_reg;
    logic signed [ZW-1:0]    cx_reg, cy_reg;
    logic [OPW-1:0]          axc_reg, ayc_reg;
    logic [SQW-1:0]          sqx_reg, sqy_reg;
    logic [15:0]             cnt_reg;
    logic                    esc_reg;
    logic [31:0]             mag_reg;

    logic [OPW-1:0]          op_a, op_b;
    logic [PW-1:0]           prod;
    logic [SQW-1:0]          p_sq;
    logic [XW-1:0]           p_x;
    logic signed [ZW-1:0]    cx_val, cy_val, zx_val, zy_val;
    logic [ZW-1:0]           ax_abs, ay_abs;
    logic [OPW-1:0]          axc_val, ayc_val;
    logic [MSW-1:0]          mag_sum;
    logic [MAGW-1:0]         mag_scaled;
    logic [31:0]             mag_sat;
    logic [16:0]             cnt_inc;
    logic                    more_iter;

    bse_mult u_mult (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // Operand selection for the shared multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            S_CX: begin
                op_a = OPW'(pix_reg.column);
                op_b = OPW'(cfg.x_step);
            end
            S_CY: begin
                op_a = OPW'(pix_reg.row);
                op_b = OPW'(cfg.y_step);
            end
            S_CROSS: begin
                op_a = axc_reg;
                op_b = ayc_reg;
            end
            S_SQX: begin
                op_a = axc_reg;
                op_b = axc_reg;
            end
            S_SQY: begin
                op_a = ayc_reg;
                op_b = ayc_reg;
            end
            default: ;
        endcase
    end

    // Product realignment: squares at FB, doubled cross term at FB-1
    assign p_sq = prod[PW-1:FB];
    assign p_x  = prod[PW-1:FB-1];

    // Point c from the pixel position
    assign cx_val = $signed({{(ZW-32){cfg.x_origin[31]}}, cfg.x_origin})
                  + $signed({1'b0, prod[ZW-2:0]});
    assign cy_val = $signed({{(ZW-32){cfg.y_origin[31]}}, cfg.y_origin})
                  - $signed({1'b0, prod[ZW-2:0]});

    // Iteration update; the previous squares are kept from the escape test
    assign zx_val = $signed({{(ZW-SQW){1'b0}}, sqx_reg})
                  - $signed({{(ZW-SQW){1'b0}}, sqy_reg}) - cx_reg;
    assign zy_val = $signed({{(ZW-XW){1'b0}}, p_x}) - cy_reg;

    // Magnitudes, clamped to 16.0
    assign ax_abs  = zx_val[ZW-1] ? ZW'(-zx_val) : ZW'(zx_val);
    assign ay_abs  = zy_val[ZW-1] ? ZW'(-zy_val) : ZW'(zy_val);
    assign axc_val = (ax_abs > CLAMP_Z) ? CLAMP_Z[OPW-1:0] : ax_abs[OPW-1:0];
    assign ayc_val = (ay_abs > CLAMP_Z) ? CLAMP_Z[OPW-1:0] : ay_abs[OPW-1:0];

    // Escape test and output scaling
    assign mag_sum    = {1'b0, sqx_reg} + {1'b0, p_sq};
    assign mag_scaled = mag_sum[MSW-1:FB-bse_pkg::MAG_FRACTION];
    assign mag_sat    = (|mag_scaled[MAGW-1:32]) ? 32'hFFFF_FFFF : mag_scaled[31:0];
    assign cnt_inc    = {1'b0, cnt_reg} + 17'd1;
    assign more_iter  = (cnt_inc < {1'b0, cfg.iteration_limit});

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_CX;
            S_CX:    state_next = S_CY;
            S_CY:    state_next = S_INIT;
            S_INIT:  state_next = (cfg.iteration_limit > 16'd1) ? S_CROSS : S_DONE;
            S_CROSS: state_next = S_UPD;
            S_UPD:   state_next = S_SQX;
            S_SQX:   state_next = S_SQY;
            S_SQY:   state_next = S_CHK;
            S_CHK:   state_next = (mag_sum > FOUR || !more_iter) ? S_DONE : S_CROSS;
            S_DONE:  if (res_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            esc_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_INIT) begin
                esc_reg <= 1'b0;
            end else if (state_reg == S_CHK && mag_sum > FOUR) begin
                esc_reg <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) pix_reg <= in_item;
            end
            S_CY: begin
                cx_reg <= cx_val;
            end
            S_INIT: begin
                cy_reg  <= cy_val;
                axc_reg <= '0;
                ayc_reg <= '0;
                sqx_reg <= '0;
                sqy_reg <= '0;
                cnt_reg <= 16'd1;
            end
            S_UPD: begin
                axc_reg <= axc_val;
                ayc_reg <= ayc_val;
            end
            S_SQY: begin
                sqx_reg <= p_sq;
            end
            S_CHK: begin
                sqy_reg <= p_sq;
                mag_reg <= mag_sat;
                if (!(mag_sum > FOUR)) cnt_reg <= cnt_inc[15:0];
            end
            default: ;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb begin
        res_item.pixel_column     = pix_reg.column;
        res_item.pixel_row        = pix_reg.row;
        res_item.escaped          = esc_reg;
        res_item.escape_count     = esc_reg ? cnt_reg : 16'd0;
        res_item.escape_magnitude = esc_reg ? mag_reg : 32'd0;
    end

endmodule

`default_nettype wire

/* rtl/burning_ship_escape_time.sv */
// Each pixel runs n iterations: the count at escape, else iteration_limit - 1, and 0
// for a limit below 2. Each iteration is five steps of one shared multiplier, and
// s_ready is high only while the sequencer is idle, so a new pixel is taken only once
// the last one's result has been passed to the output register.
// Reset (aresetn, synchronous, active low) clears the sequencer and the output valid
// and reloads the configuration registers with their default window.
`default_nettype none

module burning_ship_escape_time (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // Pixel input
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire bse_pkg::in_item_t          s_data,
    // Result output
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output bse_pkg::out_item_t              m_data,
    // Configuration writes
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [bse_pkg::IDXW-1:0]   cfg_index,
    input  wire logic [31:0]                cfg_data
);

    bse_pkg::cfg_t      cfg;
    logic               res_valid;
    logic               res_ready;
    bse_pkg::out_item_t res_item;
    logic               m_valid_reg;
    bse_pkg::out_item_t m_data_reg;

    bse_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bse_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    // Output register: loads when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) m_data_reg <= res_item;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

/* tb/sv/tb_burning_ship_escape_time.sv */
`timescale 1ns / 100ps

module tb_burning_ship_escape_time;

    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 10;
    localparam int IDLE_PERCENT   = 14;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PIXELS  = 1880;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 64;
    localparam int HOLD_CYCLES    = 1200;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PRESSURE_PHASE = 2;
    localparam int STEADY_PHASE   = 4;
    localparam logic [bse_pkg::IDXW-1:0] REG_SPARE = 3'd7;

    // Directed row: window, pixel, and a hand-worked result where one is given
    typedef struct packed {
        bse_pkg::cfg_t      window;
        bse_pkg::in_item_t  px;
        logic               has_answer;
        bse_pkg::out_item_t answer;
    } pixel_case_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic               s_valid = 1'b0;
    logic               s_ready;
    bse_pkg::in_item_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    bse_pkg::out_item_t m_data;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [bse_pkg::IDXW-1:0]     cfg_index = '0;
    logic [31:0]                  cfg_data  = '0;

    bse_pkg::cfg_t      window_now = '{x_origin: bse_pkg::RST_X_ORIGIN,
                                       x_step: bse_pkg::RST_X_STEP,
                                       y_origin: bse_pkg::RST_Y_ORIGIN,
                                       y_step: bse_pkg::RST_Y_STEP,
                                       iteration_limit: bse_pkg::RST_ITER_LIMIT};
    bse_pkg::out_item_t expected_escapes[$];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    bit        steady_run     = 1'b0;
    bit        hold_request   = 1'b0;

    burning_ship_escape_time uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ---------------------------------------------------------------
    // Escape-time predictor, fixed point with FRACTION_BITS fraction bits
    // ---------------------------------------------------------------
    function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b,
                                                   int unsigned shift);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> shift;
        return p[63:0];
    endfunction

    function automatic logic [63:0] abs64(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic bse_pkg::out_item_t ship_escape(bse_pkg::in_item_t px,
                                                       bse_pkg::cfg_t w);
        longint             cx, cy, zx, zy;
        logic [63:0]        ax, ay, sq_sum, mag;
        logic [63:0]        clamp_val, four;
        int                 n;
        bse_pkg::out_item_t r;
        r = '0;
        r.pixel_column = px.column;
        r.pixel_row    = px.row;
        clamp_val = 64'd1 << (bse_pkg::FRACTION_BITS + 4);
        four      = 64'd4 << bse_pkg::FRACTION_BITS;
        cx = longint'($signed(w.x_origin)) + $signed({54'd0, px.column} * {33'd0, w.x_step});
        cy = longint'($signed(w.y_origin)) - $signed({54'd0, px.row} * {33'd0, w.y_step});
        zx = 0;
        zy = 0;
        n  = 1;
        while (n < int'(w.iteration_limit) && !r.escaped) begin
            ax = abs64(zx);
            ay = abs64(zy);
            zx = $signed(scaled_product(ax, ax, bse_pkg::FRACTION_BITS))
               - $signed(scaled_product(ay, ay, bse_pkg::FRACTION_BITS)) - cx;
            zy = $signed(scaled_product(ax, ay, bse_pkg::FRACTION_BITS - 1)) - cy;
            // magnitude uses components clamped to 16.0
            ax = abs64(zx);
            ay = abs64(zy);
            if (ax > clamp_val) ax = clamp_val;
            if (ay > clamp_val) ay = clamp_val;
            sq_sum = scaled_product(ax, ax, bse_pkg::FRACTION_BITS)
                   + scaled_product(ay, ay, bse_pkg::FRACTION_BITS);
            if (sq_sum > four) begin
                r.escaped      = 1'b1;
                r.escape_count = 16'(n);
                mag = sq_sum >> (bse_pkg::FRACTION_BITS - bse_pkg::MAG_FRACTION);
                r.escape_magnitude = (mag > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mag[31:0];
            end
            n++;
        end
        return r;
    endfunction

    function automatic bse_pkg::cfg_t window_of(logic [31:0] xo, logic [30:0] xs,
                                                logic [31:0] yo, logic [30:0] ys,
                                                logic [15:0] lim);
        return bse_pkg::cfg_t'({xo, xs, yo, ys, lim});
    endfunction

    function automatic bse_pkg::out_item_t result_of(logic [9:0] col, logic [9:0] row,
                                                     logic esc, logic [15:0] cnt,
                                                     logic [31:0] mag);
        return bse_pkg::out_item_t'({col, row, esc, cnt, mag});
    endfunction

    // ---------------------------------------------------------------
    // Pixel and configuration drivers
    // ---------------------------------------------------------------
    task automatic send_pixel(bse_pkg::in_item_t px, logic has_answer,
                              bse_pkg::out_item_t answer);
        int gap;
        gap = 0;
        while (!steady_run && $urandom_range(0, 99) < IDLE_PERCENT) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_escapes.push_back(has_answer ? answer : ship_escape(px, window_now));
    endtask

    // Wait for every pending result, then let the engine settle
    task automatic drain_pixels();
        s_valid <= 1'b0;
        while (expected_escapes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(logic [bse_pkg::IDXW-1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            bse_pkg::REG_X_ORIGIN:   window_now.x_origin        = value;
            bse_pkg::REG_X_STEP:     window_now.x_step          = value[30:0];
            bse_pkg::REG_Y_ORIGIN:   window_now.y_origin        = value;
            bse_pkg::REG_Y_STEP:     window_now.y_step          = value[30:0];
            bse_pkg::REG_ITER_LIMIT: window_now.iteration_limit = value[15:0];
            default: ;
        endcase
    endtask

    // Unused upper bits carry junk; they must be dropped
    task automatic program_window(bse_pkg::cfg_t w, bit spare);
        write_register(bse_pkg::REG_X_ORIGIN, w.x_origin);
        write_register(bse_pkg::REG_X_STEP, {1'($urandom_range(0, 1)), w.x_step});
        write_register(bse_pkg::REG_Y_ORIGIN, w.y_origin);
        if (spare) write_register(REG_SPARE, $urandom);
        write_register(bse_pkg::REG_Y_STEP, {1'($urandom_range(0, 1)), w.y_step});
        write_register(bse_pkg::REG_ITER_LIMIT, {16'($urandom), w.iteration_limit});
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Result receiver: random back-pressure, plus one long hold-off
    // ---------------------------------------------------------------
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                m_ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Result checker
    always @(posedge aclk) begin
        bse_pkg::out_item_t want;
        if (m_valid && m_ready) begin
            if (expected_escapes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: col %0d row %0d esc %0b cnt %0d mag %h",
                             m_data.pixel_column, m_data.pixel_row, m_data.escaped,
                             m_data.escape_count, m_data.escape_magnitude);
            end else begin
                want = expected_escapes.pop_front();
                if (m_data.pixel_column !== want.pixel_column ||
                    m_data.pixel_row !== want.pixel_row ||
                    m_data.escaped !== want.escaped ||
                    m_data.escape_count !== want.escape_count ||
                    m_data.escape_magnitude !== want.escape_magnitude) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: exp col %0d row %0d esc %0b cnt %0d mag %h | %s",
                                 want.pixel_column, want.pixel_row, want.escaped,
                                 want.escape_count, want.escape_magnitude,
                                 $sformatf("got col %0d row %0d esc %0b cnt %0d mag %h",
                                           m_data.pixel_column, m_data.pixel_row,
                                           m_data.escaped, m_data.escape_count,
                                           m_data.escape_magnitude));
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        pixel_case_t        directed_cases[$];
        bse_pkg::cfg_t      rst_window;
        bse_pkg::cfg_t      far3;
        bse_pkg::cfg_t      huge;
        bse_pkg::cfg_t      ship;
        bse_pkg::cfg_t      w;
        bse_pkg::in_item_t  px;
        int                 sent;
        int                 phase;
        int                 kind;
        int                 len;

        rst_window = window_now;
        far3 = window_of(32'h3000_0000, 31'd0, 32'h0, 31'd0, 16'd0);
        huge = window_of(32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
                         16'hFFFF);
        ship = window_of(32'hE000_0000, 31'd786432, 32'h1800_0000, 31'd786432, 16'd100);

        // Reset window: c = (-2.0, 2.5) escapes at once with |z|^2 = 10.25
        directed_cases.push_back({rst_window, 10'd0, 10'd0, 1'b1,
                                  result_of(10'd0, 10'd0, 1'b1, 16'd1, 32'h0A40_0000)});
        directed_cases.push_back({rst_window, 10'd1023, 10'd1023, 1'b0, 69'd0});
        directed_cases.push_back({rst_window, 10'd512, 10'd640, 1'b0, 69'd0});
        directed_cases.push_back({rst_window, 10'd300, 10'd400, 1'b0, 69'd0});
        // Limit of zero and one: no iteration, no escape even far outside
        directed_cases.push_back({far3, 10'd0, 10'd0, 1'b1, result_of(10'd0, 10'd0, 1'b0,
                                  16'd0, 32'd0)});
        far3.iteration_limit = 16'd1;
        directed_cases.push_back({far3, 10'd1023, 10'd1023, 1'b1,
                                  result_of(10'd1023, 10'd1023, 1'b0, 16'd0, 32'd0)});
        // c = 3.0 or c = -3.0i, zero steps: escape on the first count with |z|^2 = 9
        far3.iteration_limit = 16'd2;
        directed_cases.push_back({far3, 10'd1023, 10'd0, 1'b1,
                                  result_of(10'd1023, 10'd0, 1'b1, 16'd1, 32'h0900_0000)});
        far3.iteration_limit = 16'd16;
        directed_cases.push_back({far3, 10'd0, 10'd1023, 1'b1,
                                  result_of(10'd0, 10'd1023, 1'b1, 16'd1, 32'h0900_0000)});
        directed_cases.push_back({window_of(32'h0, 31'd0, 32'hD000_0000, 31'd0, 16'd5),
                                  10'd9, 10'd9, 1'b1,
                                  result_of(10'd9, 10'd9, 1'b1, 16'd1, 32'h0900_0000)});
        // c = -2.0: |z|^2 is exactly 4 after one count, which is not an escape
        directed_cases.push_back({window_of(32'hE000_0000, 31'd0, 32'h0, 31'd0, 16'd70),
                                  10'd0, 10'd0, 1'b1,
                                  result_of(10'd0, 10'd0, 1'b1, 16'd2, 32'h2400_0000)});
        // c = 0 never leaves the origin
        directed_cases.push_back({window_of(32'h0, 31'd0, 32'h0, 31'd0, 16'd70),
                                  10'd5, 10'd7, 1'b1,
                                  result_of(10'd5, 10'd7, 1'b0, 16'd0, 32'd0)});
        // Huge components are clamped and the magnitude saturates
        directed_cases.push_back({huge, 10'd1023, 10'd1023, 1'b1,
                                  result_of(10'd1023, 10'd1023, 1'b1, 16'd1, 32'hFFFF_FFFF)});
        directed_cases.push_back({huge, 10'd0, 10'd0, 1'b0, 69'd0});
        directed_cases.push_back({huge, 10'd1023, 10'd0, 1'b0, 69'd0});
        directed_cases.push_back({window_of(32'h8000_0000, 31'd0, 32'h7FFF_FFFF, 31'd0, 16'd2),
                                  10'd512, 10'd512, 1'b0, 69'd0});
        directed_cases.push_back({window_of(32'h0, 31'h7FFF_FFFF, 32'h0, 31'h7FFF_FFFF,
                                            16'd70), 10'd1, 10'd0, 1'b0, 69'd0});
        directed_cases.push_back({window_of(32'h0, 31'h7FFF_FFFF, 32'h0, 31'h7FFF_FFFF,
                                            16'd70), 10'd0, 10'd1, 1'b0, 69'd0});
        // Inside the ship window
        directed_cases.push_back({ship, 10'd300, 10'd500, 1'b0, 69'd0});
        directed_cases.push_back({ship, 10'd700, 10'd300, 1'b0, 69'd0});
        directed_cases.push_back({ship, 10'd1023, 10'd0, 1'b0, 69'd0});
        directed_cases.push_back({ship, 10'd0, 10'd1023, 1'b0, 69'd0});
        directed_cases.push_back({ship, 10'd640, 10'd560, 1'b0, 69'd0});

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_cases[k]) begin
            if (directed_cases[k].window != window_now) begin
                drain_pixels();
                program_window(directed_cases[k].window, 1'b0);
            end
            send_pixel(directed_cases[k].px, directed_cases[k].has_answer,
                       directed_cases[k].answer);
        end

        // Random phases, each with its own window
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS) begin
            drain_pixels();
            kind = (phase == PRESSURE_PHASE) ? 99 : $urandom_range(0, 99);
            if (kind < 55) begin
                // around the ship, modest limits
                w.x_origin = 32'hE000_0000 + $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
                w.x_step   = 31'($urandom_range(32'h0004_0000, 32'h000C_0000));
                w.y_origin = $urandom_range(32'h0800_0000, 32'h2800_0000);
                w.y_step   = 31'($urandom_range(32'h0004_0000, 32'h000C_0000));
                w.iteration_limit = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(2, 48))
                                                               : 16'($urandom_range(49, 120));
            end else if (kind < 85) begin
                // any register value, with limits up to 100
                w.x_origin = $urandom;
                w.x_step   = 31'($urandom);
                w.y_origin = $urandom;
                w.y_step   = 31'($urandom);
                w.iteration_limit = 16'($urandom_range(0, 100));
            end else begin
                // real part at least 2.5: every pixel escapes on the first count
                w.x_origin = $urandom_range(32'h2800_0000, 32'h7FFF_FFFF);
                w.x_step   = 31'($urandom);
                w.y_origin = $urandom;
                w.y_step   = 31'($urandom);
                w.iteration_limit = 16'($urandom_range(65000, 65535));
            end
            program_window(w, $urandom_range(0, 3) == 0);
            steady_run = (phase == STEADY_PHASE);
            if (phase == PRESSURE_PHASE) hold_request = 1'b1;
            len = steady_run ? 200 : $urandom_range(40, 120);
            repeat (len) begin
                px.column = 10'($urandom_range(0, 1023));
                px.row    = 10'($urandom_range(0, 1023));
                send_pixel(px, 1'b0, '0);
                sent++;
            end
            phase++;
        end
        drain_pixels();
        steady_run = 1'b0;
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_escapes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
